// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the frame renderer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("renderer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("renderer assertion failed");

`endif

// ===== rtl/lwfr_pkg.sv =====
// Shared widths, codes and types of the LED wave frame renderer.
`timescale 1ns / 1ps

package lwfr_pkg;

	// Field and register widths.
	localparam int HW_W       = 10;
	localparam int COLOR_W    = 8;
	localparam int SPEED_W    = 16;
	localparam int START_W    = 12;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COUNT_W    = 32;
	localparam int WEIGHT_W   = 17;

	// Travel product and wave centre widths.
	localparam int PROD_W = COUNT_W + SPEED_W;
	localparam int FRAC_W = 8;
	localparam int POS_W  = PROD_W - FRAC_W + 2;
	localparam int DIFF_W = POS_W + 1;

	// Fixed-point constants of the cosine table.
	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam longint      ONE_Q30 = 64'sd1073741824;
	localparam longint      HALF_LSB = 64'sd16384;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED      = 3'd0,
		REG_MODE       = 3'd1,
		REG_START      = 3'd2,
		REG_HALF_WIDTH = 3'd3,
		REG_RED        = 3'd4,
		REG_GREEN      = 3'd5,
		REG_BLUE       = 3'd6
	} cfg_reg_t;

	// Travel directions.
	typedef enum logic [MODE_W-1:0] {
		TRAVEL_UP   = 2'd0,
		TRAVEL_DOWN = 2'd1,
		TRAVEL_BOTH = 2'd2
	} travel_t;

	// Frame sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_CENTRE,
		ST_SEEN,
		ST_DIFF,
		ST_CHECK,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ROM,
		ST_MULT,
		ST_ACC,
		ST_NEXT_WAVE,
		ST_EMIT
	} state_t;

	// One colour triple.
	typedef struct packed {
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
	} rgb_t;

endpackage

// ===== rtl/lwfr_cos_rom.sv =====
// Raised-cosine weight ROM, built at elaboration, with a registered read.
`timescale 1ns / 1ps

module lwfr_cos_rom #(
	parameter int COS_TABLE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic [$clog2(COS_TABLE_DEPTH)-1:0] addr,
	output logic [lwfr_pkg::WEIGHT_W-1:0]      data
);
	import lwfr_pkg::*;

	// One table entry: Taylor series of cos up to x^16 in Q30, folded about
	// the quarter period and rounded to 2^-16 units.
	function automatic logic [WEIGHT_W-1:0] cos_entry(input int k);
		logic        upper;
		logic [63:0] kr;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      c;
		longint      sum;
		upper = (2 * k) > COS_TABLE_DEPTH;
		kr    = upper ? 64'(COS_TABLE_DEPTH - k) : 64'(k);
		x     = (PI_Q30 * kr) / 64'(COS_TABLE_DEPTH);
		x2    = (x * x) >> 30;
		term  = 64'(ONE_Q30);
		c     = ONE_Q30;
		term  = ((term * x2) >> 30) / 64'd2;
		c     = c - longint'(term);
		term  = ((term * x2) >> 30) / 64'd12;
		c     = c + longint'(term);
		term  = ((term * x2) >> 30) / 64'd30;
		c     = c - longint'(term);
		term  = ((term * x2) >> 30) / 64'd56;
		c     = c + longint'(term);
		term  = ((term * x2) >> 30) / 64'd90;
		c     = c - longint'(term);
		term  = ((term * x2) >> 30) / 64'd132;
		c     = c + longint'(term);
		term  = ((term * x2) >> 30) / 64'd182;
		c     = c - longint'(term);
		term  = ((term * x2) >> 30) / 64'd240;
		c     = c + longint'(term);
		if (c < 0) begin
			c = 0;
		end
		if (upper) begin
			sum = ONE_Q30 - c + HALF_LSB;
		end else begin
			sum = ONE_Q30 + c + HALF_LSB;
		end
		return WEIGHT_W'(sum >> 15);
	endfunction

	logic [WEIGHT_W-1:0] tab [COS_TABLE_DEPTH];

	// Constant contents, one entry per index.
	for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_tab
		localparam logic [WEIGHT_W-1:0] ENTRY = cos_entry(g);
		assign tab[g] = ENTRY;
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		data <= tab[addr];
	end

endmodule

// ===== rtl/lwfr_divider.sv =====
// Restoring divider that yields one quotient bit per cycle for the table index.
`timescale 1ns / 1ps

module lwfr_divider #(
	parameter int QUOT_W  = 10,
	parameter int NUMER_W = 21
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NUMER_W-1:0]        numer,
	input  logic [lwfr_pkg::HW_W-1:0] divisor,
	output logic                      done,
	output logic [QUOT_W-1:0]         quotient
);
	import lwfr_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [HW_W-1:0]   rem_q;
	logic [QUOT_W-1:0] low_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [HW_W:0]     trial;
	logic [HW_W:0]     trial_sub;
	logic              fits;

	// One trial subtraction; the remainder always stays below the divisor.
	always_comb begin
		trial     = {rem_q, low_q[QUOT_W-1]};
		trial_sub = trial - {1'b0, divisor};
		fits      = trial >= {1'b0, divisor};
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUOT_W);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and the shift register that collects the quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= HW_W'(numer >> QUOT_W);
			low_q <= numer[QUOT_W-1:0];
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= fits ? trial_sub[HW_W-1:0] : trial[HW_W-1:0];
			low_q <= {low_q[QUOT_W-2:0], fits};
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = low_q;

endmodule

// ===== rtl/led_wave_frame_renderer.sv =====
// Top level of the LED wave frame renderer: registers, sequencer and datapath.
// Each accepted request is one frame tick; the block then streams NUM_LEDS
// pixels, index 0 first, and stays not ready until the last pixel is taken.
// A frame passes the set-up states PROD, CENTRE and SEEN and then, per pixel
// and for each of the two wave directions, DIFF and NEXT_WAVE when the
// direction is not drawn, DIFF, CHECK and NEXT_WAVE when the pixel lies outside
// the wave, and DIFF, CHECK, DIV_GO, DIV_WAIT, ROM, MULT, ACC and NEXT_WAVE
// when it lies inside; the pixel is then presented in EMIT. The inside case
// uses the shared divider, which finds the cosine table index one bit per cycle,
// followed by a registered table read and one multiply and accumulate step.
`timescale 1ns / 1ps

module led_wave_frame_renderer #(
	parameter int NUM_LEDS        = 64,
	parameter int COS_TABLE_DEPTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lwfr_pkg::HW_W-1:0]       led_index,
	output logic [lwfr_pkg::COLOR_W-1:0]    red,
	output logic [lwfr_pkg::COLOR_W-1:0]    green,
	output logic [lwfr_pkg::COLOR_W-1:0]    blue,
	output logic                            last_pixel,
	output logic                            done_res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lwfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lwfr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lwfr_pkg::*;

	localparam int PIX_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int QUOT_W  = $clog2(COS_TABLE_DEPTH);
	localparam int NUMER_W = HW_W + $clog2(COS_TABLE_DEPTH + 1);
	localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(NUM_LEDS - 1);
	localparam logic signed [DIFF_W-1:0] LIM = DIFF_W'(NUM_LEDS - 1);

	// Configuration registers.
	logic [SPEED_W-1:0]        speed_q;
	logic [MODE_W-1:0]         mode_q;
	logic signed [START_W-1:0] start_q;
	logic [HW_W-1:0]           hw_q;
	rgb_t                      colour_q;

	// Animation state.
	logic [COUNT_W-1:0] frame_count_q;
	logic               finished_q;

	// Sequencer and datapath registers.
	state_t                    state_q;
	state_t                    state_d;
	logic [PIX_W-1:0]          pix_q;
	logic                      wave_q;
	logic                      draw_en_q;
	logic [PROD_W-1:0]         prod_q;
	logic signed [POS_W-1:0]   cu_q;
	logic signed [POS_W-1:0]   cd_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic [HW_W-1:0]           d_q;
	logic                      d0_q;
	logic                      in_wave_q;
	rgb_t                      contrib_q;
	rgb_t                      acc_q;

	// Combinational helpers.
	logic                      up_en;
	logic                      dn_en;
	logic                      wave_en;
	logic signed [POS_W-1:0]   c_sel;
	logic signed [DIFF_W-1:0]  hw_s;
	logic signed [DIFF_W-1:0]  cu_x;
	logic signed [DIFF_W-1:0]  cd_x;
	logic                      seen;
	logic                      in_wave;
	logic [HW_W-1:0]           d_abs;
	logic                      div_start;
	logic                      div_done;
	logic [NUMER_W-1:0]        numer;
	logic [QUOT_W-1:0]         k_idx;
	logic [WEIGHT_W-1:0]       weight;
	logic [COLOR_W+WEIGHT_W-1:0] mul_r;
	logic [COLOR_W+WEIGHT_W-1:0] mul_g;
	logic [COLOR_W+WEIGHT_W-1:0] mul_b;
	logic [COLOR_W:0]          add_r;
	logic [COLOR_W:0]          add_g;
	logic [COLOR_W:0]          add_b;
	logic [COLOR_W+1:0]        sum_r;
	logic [COLOR_W+1:0]        sum_g;
	logic [COLOR_W+1:0]        sum_b;
	logic                      in_req;
	logic                      out_req;

	assign in_req  = in_valid && in_ready;
	assign out_req = out_valid && out_ready;

	// Configuration writes; the port always accepts.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= SPEED_W'(256);
			mode_q     <= TRAVEL_BOTH;
			start_q    <= '0;
			hw_q       <= HW_W'(8);
			colour_q.r <= '1;
			colour_q.g <= '1;
			colour_q.b <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SPEED:      speed_q    <= cfg_data[SPEED_W-1:0];
				REG_MODE:       mode_q     <= cfg_data[MODE_W-1:0];
				REG_START:      start_q    <= $signed(cfg_data[START_W-1:0]);
				REG_HALF_WIDTH: hw_q       <= cfg_data[HW_W-1:0];
				REG_RED:        colour_q.r <= cfg_data[COLOR_W-1:0];
				REG_GREEN:      colour_q.g <= cfg_data[COLOR_W-1:0];
				REG_BLUE:       colour_q.b <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Direction enables and the centre of the wave in hand.
	always_comb begin
		up_en   = (mode_q == TRAVEL_UP) || (mode_q == TRAVEL_BOTH);
		dn_en   = (mode_q == TRAVEL_DOWN) || (mode_q == TRAVEL_BOTH);
		wave_en = draw_en_q && (wave_q ? dn_en : up_en);
		c_sel   = wave_q ? cd_q : cu_q;
		hw_s    = $signed(DIFF_W'(hw_q));
		cu_x    = DIFF_W'(cu_q);
		cd_x    = DIFF_W'(cd_q);
	end

	// A drawn wave is seen when its span reaches any pixel of the strip.
	always_comb begin
		seen = (hw_q != '0) && (
			(up_en && (cu_x + hw_s > 0) && (cu_x - hw_s < LIM)) ||
			(dn_en && (cd_x + hw_s > 0) && (cd_x - hw_s < LIM)));
	end

	// Distance test of the pixel against the wave centre.
	always_comb begin
		if (diff_q[DIFF_W-1]) begin
			in_wave = (diff_q + hw_s) > 0;
			d_abs   = HW_W'(~diff_q[HW_W-1:0] + 1'b1);
		end else begin
			in_wave = diff_q < hw_s;
			d_abs   = diff_q[HW_W-1:0];
		end
	end

	// Table index numerator d * DEPTH for the shared divider.
	assign numer = NUMER_W'(d_q) * NUMER_W'(COS_TABLE_DEPTH);

	lwfr_divider #(
		.QUOT_W  (QUOT_W),
		.NUMER_W (NUMER_W)
	) u_lwfr_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (numer),
		.divisor  (hw_q),
		.done     (div_done),
		.quotient (k_idx)
	);

	lwfr_cos_rom #(
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH)
	) u_lwfr_cos_rom (
		.clk  (clk),
		.addr (k_idx),
		.data (weight)
	);

	// Colour scaling and saturating accumulation; the centre counts twice.
	always_comb begin
		mul_r = (COLOR_W + WEIGHT_W)'(colour_q.r) * (COLOR_W + WEIGHT_W)'(weight);
		mul_g = (COLOR_W + WEIGHT_W)'(colour_q.g) * (COLOR_W + WEIGHT_W)'(weight);
		mul_b = (COLOR_W + WEIGHT_W)'(colour_q.b) * (COLOR_W + WEIGHT_W)'(weight);
		add_r = d0_q ? {contrib_q.r, 1'b0} : {1'b0, contrib_q.r};
		add_g = d0_q ? {contrib_q.g, 1'b0} : {1'b0, contrib_q.g};
		add_b = d0_q ? {contrib_q.b, 1'b0} : {1'b0, contrib_q.b};
		sum_r = (COLOR_W + 2)'(acc_q.r) + (COLOR_W + 2)'(add_r);
		sum_g = (COLOR_W + 2)'(acc_q.g) + (COLOR_W + 2)'(add_g);
		sum_b = (COLOR_W + 2)'(acc_q.b) + (COLOR_W + 2)'(add_b);
	end

	// Next-state logic of the frame sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_req) state_d = ST_PROD;
			ST_PROD:      state_d = ST_CENTRE;
			ST_CENTRE:    state_d = ST_SEEN;
			ST_SEEN:      state_d = ST_DIFF;
			ST_DIFF:      state_d = wave_en ? ST_CHECK : ST_NEXT_WAVE;
			ST_CHECK:     state_d = in_wave ? ST_DIV_GO : ST_NEXT_WAVE;
			ST_DIV_GO:    state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (div_done) state_d = ST_ROM;
			ST_ROM:       state_d = ST_MULT;
			ST_MULT:      state_d = ST_ACC;
			ST_ACC:       state_d = ST_NEXT_WAVE;
			ST_NEXT_WAVE: state_d = wave_q ? ST_EMIT : ST_DIFF;
			ST_EMIT: begin
				if (out_ready) begin
					state_d = (pix_q == LAST_PIX) ? ST_IDLE : ST_DIFF;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		div_start = (state_q == ST_DIV_GO);
	end

	// Control registers: state, animation state and loop positions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_count_q <= '0;
			finished_q    <= 1'b0;
			draw_en_q     <= 1'b0;
			pix_q         <= '0;
			wave_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_req && restart) begin
				frame_count_q <= '0;
				finished_q    <= 1'b0;
			end
			if (state_q == ST_SEEN) begin
				draw_en_q <= !finished_q;
				pix_q     <= '0;
				wave_q    <= 1'b0;
				if (!finished_q) begin
					frame_count_q <= frame_count_q + 1'b1;
					finished_q    <= !seen;
				end
			end
			if (state_q == ST_NEXT_WAVE) begin
				wave_q <= !wave_q;
			end
			if (out_req && pix_q != LAST_PIX) begin
				pix_q <= pix_q + 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_PROD) begin
			prod_q <= PROD_W'(frame_count_q) * PROD_W'(speed_q);
		end
		if (state_q == ST_CENTRE) begin
			cu_q <= POS_W'(start_q) + $signed(POS_W'(prod_q[PROD_W-1:FRAC_W]));
			cd_q <= POS_W'(start_q) - $signed(POS_W'(prod_q[PROD_W-1:FRAC_W]));
		end
		if (state_q == ST_SEEN || out_req) begin
			acc_q <= '0;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= $signed(DIFF_W'(pix_q)) - DIFF_W'(c_sel);
		end
		if (state_q == ST_CHECK) begin
			d_q       <= d_abs;
			d0_q      <= (diff_q == '0);
			in_wave_q <= in_wave;
		end
		if (state_q == ST_MULT) begin
			contrib_q.r <= COLOR_W'(mul_r >> 16);
			contrib_q.g <= COLOR_W'(mul_g >> 16);
			contrib_q.b <= COLOR_W'(mul_b >> 16);
		end
		if (state_q == ST_ACC && in_wave_q) begin
			acc_q.r <= (sum_r > (COLOR_W + 2)'(255)) ? '1 : sum_r[COLOR_W-1:0];
			acc_q.g <= (sum_g > (COLOR_W + 2)'(255)) ? '1 : sum_g[COLOR_W-1:0];
			acc_q.b <= (sum_b > (COLOR_W + 2)'(255)) ? '1 : sum_b[COLOR_W-1:0];
		end
	end

	// Result fields, held while the pixel waits to be taken.
	assign led_index  = HW_W'(pix_q);
	assign red        = acc_q.r;
	assign green      = acc_q.g;
	assign blue       = acc_q.b;
	assign last_pixel = (pix_q == LAST_PIX);
	assign done_res   = finished_q;

endmodule

// ===== rtl/lwfr_checker.sv =====
// Port-level checker of the frame renderer and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lwfr_checker #(
	parameter int NUM_LEDS = 64
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [lwfr_pkg::HW_W-1:0]       led_index,
	input logic [lwfr_pkg::COLOR_W-1:0]    red,
	input logic [lwfr_pkg::COLOR_W-1:0]    green,
	input logic [lwfr_pkg::COLOR_W-1:0]    blue,
	input logic                            last_pixel,
	input logic                            done_res
);
	import lwfr_pkg::*;

	// A new request is never taken while a pixel is on offer.
	`ASSERT_IMPLIES(a_no_overlap, clk, arst_n, in_ready, !out_valid)

	// Rendering a frame takes the block out of the ready state.
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready)

	// Once the final pixel is taken the block is ready for the next frame.
	`ASSERT_NEXT(a_idle_after_last, clk, arst_n, out_valid && out_ready && last_pixel, in_ready)

	// The final pixel carries the highest index of the strip.
	`ASSERT_IMPLIES(a_last_index, clk, arst_n, out_valid && last_pixel, led_index == HW_W'(NUM_LEDS - 1))

	// A stalled pixel keeps its fields.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(led_index) && $stable(red) && $stable(green) && $stable(blue) && $stable(done_res))

endmodule

bind led_wave_frame_renderer lwfr_checker #(.NUM_LEDS(NUM_LEDS)) u_lwfr_checker (.*);
